@@ src/block_request_coalescer_top_assert.svh @@
// Assertion macros for the block request coalescer
`ifndef BLOCK_REQUEST_COALESCER_TOP_ASSERT_SVH
`define BLOCK_REQUEST_COALESCER_TOP_ASSERT_SVH
`ifndef SYNTH
`define BRC_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("brc assertion failed");
`define BRC_ASSERT_NEVER(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("brc assertion failed");
`else
`define BRC_ASSERT(lbl, prop)
`define BRC_ASSERT_NEVER(lbl, expr)
`endif
`endif

@@ src/brc_pkg.sv @@
// Shared types and constants of the block request coalescer
package brc_pkg;
   localparam int BLOCK_BYTES  = 4096;
   localparam int BYTE_LIMIT   = 262144;
   localparam int LIMIT_BLOCKS = BYTE_LIMIT / BLOCK_BYTES;
   localparam int CTX_FIELD_W  = 4;
   localparam int SEG_LEN_W    = 19;
   localparam int BUF_W        = 48;
   localparam int BC_W         = 7;

   localparam logic [1:0] OP_READ    = 2'd0;
   localparam logic [1:0] OP_WRITE   = 2'd1;
   localparam logic [1:0] OP_MIGRATE = 2'd2;
   localparam logic [1:0] OP_INVALID = 2'd3;
   localparam logic [1:0] DT_META    = 2'd2;
   localparam logic       FUNC_SUBMIT = 1'b0;
   localparam logic       FUNC_FLUSH  = 1'b1;

   localparam logic [1:0] CSR_SEG0_START  = 2'd0;
   localparam logic [1:0] CSR_MAIN_START  = 2'd1;
   localparam logic [1:0] CSR_MAIN_COUNT  = 2'd2;
   localparam logic [1:0] CSR_CHECK_ADDR  = 2'd3;

   typedef enum logic [1:0] {
      KIND_ACK    = 2'd0,
      KIND_DESC   = 2'd1,
      KIND_REJECT = 2'd2
   } kind_type;

   typedef struct packed {
      logic                   reject;
      logic                   func;
      logic [1:0]             op;
      logic [1:0]             dtype;
      logic [CTX_FIELD_W-1:0] ctx;
      logic [31:0]            blk;
      logic [BUF_W-1:0]       buffer;
      logic                   flush_now;
   } cmd_type;

   typedef struct packed {
      logic [BUF_W-1:0]     addr;
      logic [SEG_LEN_W-1:0] len;
   } seg_type;

   typedef struct packed {
      kind_type             kind;
      logic                 flushed_prior;
      logic [7:0]           req_index;
      logic [1:0]           op;
      logic [1:0]           dtype;
      logic [31:0]          start_block;
      logic [BC_W-1:0]      blk_total;
      logic [4:0]           seg_count;
      logic [BUF_W-1:0]     seg_address;
      logic [SEG_LEN_W-1:0] seg_length;
      logic                 descriptor_end;
      logic                 last;
   } rsp_type;
endpackage

@@ src/block_request_coalescer_top.sv @@
// Block request coalescer top level
//
// Input queue: drive a request word and raise req_push; it is taken on a
// clock edge where req_full is low. Results come out as a queue: while
// rsp_empty is low the oldest result word is on the rsp_ ports, and it is
// taken on an edge where rsp_pop is high. Every request ends with one word
// that has rsp_last set (acknowledge or reject); flushes put one descriptor
// word per segment ahead of it.
// Back end states per request: IDLE takes it off the queue, then FETCH; a
// reject or empty flush goes on to ACK, a merge to LOOK and ACK, a request
// that opens a new batch to LOOK, START and ACK. Each flushed segment adds
// FRD (segment memory read) and FEMIT (result load). An accepted request is
// registered in the queue before the back end sees it, and a word shows in
// the cycle after it is loaded. A two-word queue lets the front take new
// requests while the back end is busy. Reset (synchronous, active high)
// empties all batches, the queues and the result register, and restores the
// control registers. When rsp_pop stays low, the back end holds and the input
// queue fills, then req_full rises. The user must write the control
// registers via csr_we/csr_index/csr_data only while idle (not checked).
module block_request_coalescer_top import brc_pkg::*; #(
   parameter int VEC_MAX         = 16,
   parameter int DATA_TYPES      = 3,
   parameter int REQ_INDEX_LIMIT = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_func,
   input  logic [1:0]  req_op,
   input  logic [1:0]  req_data_type,
   input  logic [31:0] req_block_addr,
   input  logic [47:0] req_buffer_addr,
   input  logic        req_force_submit,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_kind,
   output logic        rsp_flushed_prior,
   output logic [7:0]  rsp_req_index,
   output logic [1:0]  rsp_op_out,
   output logic [1:0]  rsp_dtype_out,
   output logic [31:0] rsp_start_block,
   output logic [6:0]  rsp_block_count,
   output logic [4:0]  rsp_seg_count,
   output logic [47:0] rsp_seg_address,
   output logic [18:0] rsp_seg_length,
   output logic        rsp_descriptor_end,
   output logic        rsp_last
);
   logic    q_push, q_full, q_pop, q_valid;
   cmd_type q_in, q_out;
   rsp_type rsp;

   brc_front #(.DATA_TYPES(DATA_TYPES)) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_push         (req_push),
      .req_func         (req_func),
      .req_op           (req_op),
      .req_data_type    (req_data_type),
      .req_block_addr   (req_block_addr),
      .req_buffer_addr  (req_buffer_addr),
      .req_force_submit (req_force_submit),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_data           (q_in)
   );

   brc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_data  (q_out)
   );

   brc_back #(
      .VEC_MAX         (VEC_MAX),
      .DATA_TYPES      (DATA_TYPES),
      .REQ_INDEX_LIMIT (REQ_INDEX_LIMIT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (q_out),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp)
   );

   assign req_full           = q_full;
   assign rsp_kind           = rsp.kind;
   assign rsp_flushed_prior  = rsp.flushed_prior;
   assign rsp_req_index      = rsp.req_index;
   assign rsp_op_out         = rsp.op;
   assign rsp_dtype_out      = rsp.dtype;
   assign rsp_start_block    = rsp.start_block;
   assign rsp_block_count    = rsp.blk_total;
   assign rsp_seg_count      = rsp.seg_count;
   assign rsp_seg_address    = rsp.seg_address;
   assign rsp_seg_length     = rsp.seg_length;
   assign rsp_descriptor_end = rsp.descriptor_end;
   assign rsp_last           = rsp.last;
endmodule

@@ src/brc_front.sv @@
// Front end: control registers, request validation and context selection
module brc_front import brc_pkg::*; #(
   parameter int DATA_TYPES = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data,
   input  logic        req_push,
   input  logic        req_func,
   input  logic [1:0]  req_op,
   input  logic [1:0]  req_data_type,
   input  logic [31:0] req_block_addr,
   input  logic [47:0] req_buffer_addr,
   input  logic        req_force_submit,
   input  logic        q_full,
   output logic        q_push,
   output cmd_type     q_data
);
   logic [31:0] seg0_ff, seg0_in, mstart_ff, mstart_in, mcount_ff, mcount_in;
   logic        check_ff, check_in;
   logic        op_bad, dt_bad, meta_ok, main_ok, addr_ok;
   logic [32:0] main_end;
   int          ctx_full;

   always_comb begin
      seg0_in   = seg0_ff;
      mstart_in = mstart_ff;
      mcount_in = mcount_ff;
      check_in  = check_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SEG0_START: seg0_in   = csr_data;
            CSR_MAIN_START: mstart_in = csr_data;
            CSR_MAIN_COUNT: mcount_in = csr_data;
            CSR_CHECK_ADDR: check_in  = csr_data[0];
            default:        check_in  = check_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg0_ff   <= '0;
         mstart_ff <= '0;
         mcount_ff <= '0;
         check_ff  <= 1'b1;
      end else begin
         seg0_ff   <= seg0_in;
         mstart_ff <= mstart_in;
         mcount_ff <= mcount_in;
         check_ff  <= check_in;
      end
   end

   assign op_bad   = (req_op == OP_INVALID);
   assign dt_bad   = (int'(req_data_type) >= DATA_TYPES);
   assign main_end = {1'b0, mstart_ff} + {1'b0, mcount_ff};
   assign meta_ok  = (req_block_addr >= seg0_ff) && (req_block_addr < mstart_ff);
   assign main_ok  = (req_block_addr >= mstart_ff) && ({1'b0, req_block_addr} < main_end);
   assign addr_ok  = !check_ff || ((req_data_type == DT_META) ? meta_ok : main_ok);

   always_comb begin
      if (req_op == OP_MIGRATE) begin
         ctx_full = 2 * DATA_TYPES;
      end else begin
         ctx_full = int'(req_op) * DATA_TYPES + int'(req_data_type);
      end
   end

   always_comb begin
      q_data.reject    = op_bad || dt_bad || (req_func == FUNC_SUBMIT && !addr_ok);
      q_data.func      = req_func;
      q_data.op        = req_op;
      q_data.dtype     = (req_op == OP_MIGRATE) ? 2'd0 : req_data_type;
      q_data.ctx       = CTX_FIELD_W'(ctx_full);
      q_data.blk       = req_block_addr;
      q_data.buffer    = req_buffer_addr;
      q_data.flush_now = req_force_submit;
   end

   assign q_push = req_push && !q_full;
endmodule

@@ src/brc_queue.sv @@
// Two-word queue between front end and back end
module brc_queue import brc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    valid,
   output cmd_type pop_data
);
   cmd_type    mem_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full     = (cnt_ff == 2'd2);
   assign valid    = (cnt_ff != 2'd0);
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? !wr_ff : wr_ff;
      rd_in  = pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

@@ src/brc_back.sv @@
// Back end: batch contexts, segment memory, flush sequencer and result register
`include "block_request_coalescer_top_assert.svh"
module brc_back import brc_pkg::*; #(
   parameter int VEC_MAX         = 16,
   parameter int DATA_TYPES      = 3,
   parameter int REQ_INDEX_LIMIT = 256
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_valid,
   input  cmd_type q_data,
   output logic    q_pop,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);
   localparam int NCTX   = 2 * DATA_TYPES + 1;
   localparam int CTX_W  = $clog2(NCTX);
   localparam int SEG_W  = $clog2(VEC_MAX + 1);
   localparam int SIDX_W = (VEC_MAX > 1) ? $clog2(VEC_MAX) : 1;
   localparam int DEPTH  = NCTX * VEC_MAX;
   localparam int MA_W   = $clog2(DEPTH);
   localparam int RIDX_W = $clog2(REQ_INDEX_LIMIT);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_FETCH = 7'b0000010,
      S_LOOK  = 7'b0000100,
      S_START = 7'b0001000,
      S_FRD   = 7'b0010000,
      S_FEMIT = 7'b0100000,
      S_ACK   = 7'b1000000
   } state_type;

   state_type           state_ff, state_in;
   cmd_type             cmd_ff, cmd_in;
   logic [SIDX_W-1:0]   seg_ff, seg_in;
   logic                flushed_ff, flushed_in, restart_ff, restart_in;
   logic [RIDX_W-1:0]   cnt_ff, cnt_in;
   logic [31:0]         ctx_start_ff [NCTX];
   logic [31:0]         ctx_start_in [NCTX];
   logic [BC_W-1:0]     ctx_blk_ff [NCTX];
   logic [BC_W-1:0]     ctx_blk_in [NCTX];
   logic [SEG_W-1:0]    ctx_seg_ff [NCTX];
   logic [SEG_W-1:0]    ctx_seg_in [NCTX];
   seg_type             mem [DEPTH];
   seg_type             rd_ff, wd;
   logic                we, re;
   logic [MA_W-1:0]     wa, ra;
   logic                out_valid_ff, out_valid_in, out_load, slot_free;
   rsp_type             out_ff, out_in;

   logic [CTX_W-1:0]    cidx;
   logic [SEG_W-1:0]    n, n_m1;
   logic [SIDX_W-1:0]   sidx_last;
   logic [BC_W-1:0]     bc;
   logic [31:0]         sb;
   logic                merge, contig, desc_end;
   logic [RIDX_W+7:0]   ridx_ext;
   logic [SEG_W+4:0]    n_ext;

   function automatic logic [MA_W-1:0] maddr(input logic [CTX_W-1:0] c,
                                            input logic [SIDX_W-1:0] s);
      int a;
      a = int'(c) * VEC_MAX + int'(s);
      return MA_W'(a);
   endfunction

   assign cidx      = cmd_ff.ctx[CTX_W-1:0];
   assign n         = ctx_seg_ff[cidx];
   assign bc        = ctx_blk_ff[cidx];
   assign sb        = ctx_start_ff[cidx];
   assign n_m1      = n - 1'b1;
   assign sidx_last = n_m1[SIDX_W-1:0];
   assign merge     = (n != '0) && (cmd_ff.blk == sb + 32'(bc)) &&
                      (int'(n) < VEC_MAX) && (int'(bc) + 1 <= LIMIT_BLOCKS);
   assign contig    = ((rd_ff.addr + BUF_W'(rd_ff.len)) == cmd_ff.buffer);
   assign desc_end  = (seg_ff == sidx_last);
   assign ridx_ext  = {8'b0, cnt_ff};
   assign n_ext     = {5'b0, n};
   assign slot_free = !out_valid_ff || rsp_pop;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      seg_in       = seg_ff;
      flushed_in   = flushed_ff;
      restart_in   = restart_ff;
      cnt_in       = cnt_ff;
      ctx_start_in = ctx_start_ff;
      ctx_blk_in   = ctx_blk_ff;
      ctx_seg_in   = ctx_seg_ff;
      q_pop        = 1'b0;
      we           = 1'b0;
      wa           = '0;
      wd           = '0;
      re           = 1'b0;
      ra           = '0;
      out_load     = 1'b0;
      out_in       = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop      = 1'b1;
               cmd_in     = q_data;
               flushed_in = 1'b0;
               state_in   = S_FETCH;
            end
         end
         S_FETCH: begin
            if (cmd_ff.reject) begin
               state_in = S_ACK;
            end else if (cmd_ff.func == FUNC_FLUSH) begin
               seg_in     = '0;
               restart_in = 1'b0;
               state_in   = (n != '0) ? S_FRD : S_ACK;
            end else begin
               re       = 1'b1;
               ra       = maddr(cidx, sidx_last);
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            if (merge) begin
               we = 1'b1;
               if (contig) begin
                  wa = maddr(cidx, sidx_last);
                  wd = '{addr: rd_ff.addr, len: rd_ff.len + SEG_LEN_W'(BLOCK_BYTES)};
               end else begin
                  wa = maddr(cidx, SIDX_W'(sidx_last + 1'b1));
                  wd = '{addr: cmd_ff.buffer, len: SEG_LEN_W'(BLOCK_BYTES)};
                  ctx_seg_in[cidx] = n + 1'b1;
               end
               ctx_blk_in[cidx] = bc + 1'b1;
               seg_in     = '0;
               restart_in = 1'b0;
               state_in   = cmd_ff.flush_now ? S_FRD : S_ACK;
            end else if (n != '0) begin
               flushed_in = 1'b1;
               seg_in     = '0;
               restart_in = 1'b1;
               state_in   = S_FRD;
            end else begin
               state_in = S_START;
            end
         end
         S_START: begin
            we = 1'b1;
            wa = maddr(cidx, '0);
            wd = '{addr: cmd_ff.buffer, len: SEG_LEN_W'(BLOCK_BYTES)};
            ctx_start_in[cidx] = cmd_ff.blk;
            ctx_blk_in[cidx]   = BC_W'(1);
            ctx_seg_in[cidx]   = SEG_W'(1);
            seg_in     = '0;
            restart_in = 1'b0;
            state_in   = cmd_ff.flush_now ? S_FRD : S_ACK;
         end
         S_FRD: begin
            re       = 1'b1;
            ra       = maddr(cidx, seg_ff);
            state_in = S_FEMIT;
         end
         S_FEMIT: begin
            if (slot_free) begin
               out_load              = 1'b1;
               out_in.kind           = KIND_DESC;
               out_in.flushed_prior  = flushed_ff;
               out_in.req_index      = ridx_ext[7:0];
               out_in.op             = cmd_ff.op;
               out_in.dtype          = cmd_ff.dtype;
               out_in.start_block    = sb;
               out_in.blk_total      = bc;
               out_in.seg_count      = n_ext[4:0];
               out_in.seg_address    = rd_ff.addr;
               out_in.seg_length     = rd_ff.len;
               out_in.descriptor_end = desc_end;
               out_in.last           = 1'b0;
               if (desc_end) begin
                  ctx_start_in[cidx] = '0;
                  ctx_blk_in[cidx]   = '0;
                  ctx_seg_in[cidx]   = '0;
                  cnt_in = (cnt_ff == RIDX_W'(REQ_INDEX_LIMIT - 1)) ? '0 : cnt_ff + 1'b1;
                  restart_in = 1'b0;
                  state_in   = restart_ff ? S_START : S_ACK;
               end else begin
                  seg_in   = seg_ff + 1'b1;
                  state_in = S_FRD;
               end
            end
         end
         S_ACK: begin
            if (slot_free) begin
               out_load             = 1'b1;
               out_in.kind          = cmd_ff.reject ? KIND_REJECT : KIND_ACK;
               out_in.flushed_prior = cmd_ff.reject ? 1'b0 : flushed_ff;
               out_in.last          = 1'b1;
               state_in             = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign out_valid_in = out_load ? 1'b1 : (rsp_pop ? 1'b0 : out_valid_ff);
   assign rsp_empty    = !out_valid_ff;
   assign rsp_data     = out_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      if (re) begin
         rd_ff <= mem[ra];
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cmd_ff       <= '0;
         seg_ff       <= '0;
         flushed_ff   <= 1'b0;
         restart_ff   <= 1'b0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < NCTX; i++) begin
            ctx_start_ff[i] <= '0;
            ctx_blk_ff[i]   <= '0;
            ctx_seg_ff[i]   <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cmd_ff       <= cmd_in;
         seg_ff       <= seg_in;
         flushed_ff   <= flushed_in;
         restart_ff   <= restart_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
         ctx_start_ff <= ctx_start_in;
         ctx_blk_ff   <= ctx_blk_in;
         ctx_seg_ff   <= ctx_seg_in;
      end
   end

   `BRC_ASSERT_NEVER(a_seg_overflow, int'(n) > VEC_MAX)
   `BRC_ASSERT(a_ctx_consistent, (n != '0) == (bc != '0))
   `BRC_ASSERT(a_flush_nonempty, (state_ff == S_FEMIT) |-> (n != '0))
endmodule
